/* sv/x25fp_pkg.sv */
// Shared types and constants for the X.25 facilities field parser.
// Used by every module of the block; depends on nothing.
package x25fp_pkg;

  // Element class, taken from the top two bits of a code byte
  localparam logic [1:0] CLS_A = 2'b00;
  localparam logic [1:0] CLS_B = 2'b01;
  localparam logic [1:0] CLS_C = 2'b10;
  localparam logic [1:0] CLS_D = 2'b11;

  // Facility codes that are captured
  localparam logic [7:0] FAC_REVERSE = 8'h01;
  localparam logic [7:0] FAC_THRUPUT = 8'h02;
  localparam logic [7:0] FAC_PKTSIZE = 8'h42;
  localparam logic [7:0] FAC_WINSIZE = 8'h43;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } beat_t;

  // One result item
  typedef struct packed {
    logic       reverse_charge;
    logic [7:0] throughput;
    logic [7:0] pkt_size_in;
    logic [7:0] pkt_size_out;
    logic [7:0] win_size_in;
    logic [7:0] win_size_out;
    logic [8:0] bytes_used;
    logic       malformed;
  } result_t;

endpackage

/* sv/x25fp_in_stage.sv */
// Input register of the facilities parser: holds one accepted beat.
// Depends on x25fp_pkg.
module x25fp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  x25fp_pkg::beat_t in_beat,
  input  logic             advance,
  output logic             held_valid,
  output x25fp_pkg::beat_t held_beat
);
  import x25fp_pkg::*;

  logic accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_beat <= in_beat;
    end
  end

endmodule

/* sv/x25fp_walker.sv */
// Facility element walker: field and element state plus captured values.
// Decodes one held beat per step and builds the result. Depends on x25fp_pkg.
module x25fp_walker (
  input  logic               clk,
  input  logic               rst,
  input  x25fp_pkg::beat_t   beat,
  input  logic               step,
  output logic               emit,
  output x25fp_pkg::result_t result
);
  import x25fp_pkg::*;

  logic       in_field,      in_field_next;
  logic [7:0] remaining,     remaining_next;
  logic [7:0] stated_length, stated_length_next;
  logic [7:0] element_code,  element_code_next;
  logic [7:0] element_left,  element_left_next;
  logic [1:0] element_pos,   element_pos_next;
  logic       cap_rev,       cap_rev_next;
  logic [7:0] cap_thr,       cap_thr_next;
  logic [7:0] cap_pin,       cap_pin_next;
  logic [7:0] cap_pout,      cap_pout_next;
  logic [7:0] cap_win,       cap_win_next;
  logic [7:0] cap_wout,      cap_wout_next;
  logic       bad;

  always_comb begin
    in_field_next      = in_field;
    remaining_next     = remaining;
    stated_length_next = stated_length;
    element_code_next  = element_code;
    element_left_next  = element_left;
    element_pos_next   = element_pos;
    cap_rev_next       = cap_rev;
    cap_thr_next       = cap_thr;
    cap_pin_next       = cap_pin;
    cap_pout_next      = cap_pout;
    cap_win_next       = cap_win;
    cap_wout_next      = cap_wout;
    emit               = 1'b0;
    bad                = 1'b0;

    if (beat.start_req) begin
      // length byte: clear everything and open a new field, or emit at once if zero
      cap_rev_next       = 1'b0;
      cap_thr_next       = 8'd0;
      cap_pin_next       = 8'd0;
      cap_pout_next      = 8'd0;
      cap_win_next       = 8'd0;
      cap_wout_next      = 8'd0;
      stated_length_next = beat.data_byte;
      remaining_next     = beat.data_byte;
      element_code_next  = 8'd0;
      element_left_next  = 8'd0;
      element_pos_next   = 2'd0;
      if (beat.data_byte == 8'd0) begin
        in_field_next = 1'b0;
        emit          = 1'b1;
      end else begin
        in_field_next = 1'b1;
      end
    end else if (in_field) begin
      if (element_left == 8'd0) begin
        // code byte of a new element
        element_code_next = beat.data_byte;
        element_pos_next  = 2'd0;
        case (beat.data_byte[7:6])
          CLS_A:   element_left_next = 8'd1;
          CLS_B:   element_left_next = 8'd2;
          CLS_C:   element_left_next = 8'd3;
          default: element_left_next = 8'd1; // class D: length byte next
        endcase
      end else if (element_code[7:6] == CLS_D) begin
        if (element_pos == 2'd0) begin
          element_left_next = beat.data_byte;
          element_pos_next  = 2'd1;
        end else begin
          element_left_next = element_left - 8'd1;
        end
      end else begin
        if (element_code == FAC_REVERSE && element_pos == 2'd0) begin
          cap_rev_next = beat.data_byte[0];
        end else if (element_code == FAC_THRUPUT && element_pos == 2'd0) begin
          cap_thr_next = beat.data_byte;
        end else if (element_code == FAC_PKTSIZE && element_pos == 2'd0) begin
          cap_pin_next = beat.data_byte;
        end else if (element_code == FAC_PKTSIZE && element_pos == 2'd1) begin
          cap_pout_next = beat.data_byte;
        end else if (element_code == FAC_WINSIZE && element_pos == 2'd0) begin
          cap_win_next = beat.data_byte;
        end else if (element_code == FAC_WINSIZE && element_pos == 2'd1) begin
          cap_wout_next = beat.data_byte;
        end
        element_left_next = element_left - 8'd1;
        element_pos_next  = element_pos + 2'd1;
      end

      remaining_next = remaining - 8'd1;
      if (remaining_next == 8'd0) begin
        in_field_next = 1'b0;
        emit          = 1'b1;
        bad           = (element_left_next != 8'd0);
      end
    end
  end

  always_comb begin
    result.reverse_charge = cap_rev_next;
    result.throughput     = cap_thr_next;
    result.pkt_size_in    = cap_pin_next;
    result.pkt_size_out   = cap_pout_next;
    result.win_size_in    = cap_win_next;
    result.win_size_out   = cap_wout_next;
    result.bytes_used     = {1'b0, stated_length_next} + 9'd1;
    result.malformed      = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_field      <= 1'b0;
      remaining     <= 8'd0;
      stated_length <= 8'd0;
      element_code  <= 8'd0;
      element_left  <= 8'd0;
      element_pos   <= 2'd0;
      cap_rev       <= 1'b0;
      cap_thr       <= 8'd0;
      cap_pin       <= 8'd0;
      cap_pout      <= 8'd0;
      cap_win       <= 8'd0;
      cap_wout      <= 8'd0;
    end else if (step) begin
      in_field      <= in_field_next;
      remaining     <= remaining_next;
      stated_length <= stated_length_next;
      element_code  <= element_code_next;
      element_left  <= element_left_next;
      element_pos   <= element_pos_next;
      cap_rev       <= cap_rev_next;
      cap_thr       <= cap_thr_next;
      cap_pin       <= cap_pin_next;
      cap_pout      <= cap_pout_next;
      cap_win       <= cap_win_next;
      cap_wout      <= cap_wout_next;
    end
  end

endmodule

/* sv/x25fp_out_stage.sv */
// Result register of the facilities parser: holds one result beat
// until the receiver takes it. Depends on x25fp_pkg.
module x25fp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  x25fp_pkg::result_t load_result,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_stall,
  output x25fp_pkg::result_t out_result
);
  import x25fp_pkg::*;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

/* sv/x25_facility_parser.sv */
// X.25 facilities field parser, top level. Depends on x25fp_pkg and submodules.
// Throughput: one byte per cycle, sustained, while results are taken.
// A field's last byte passes the input register, then is decoded into the
// result register, where its result becomes valid.
// The input stalls only when a byte that ends a field meets a full, stalled
// result register. Synchronous reset clears valids, field state and captures.
module x25_facility_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reverse_charge,
  output logic [7:0] throughput,
  output logic [7:0] pkt_size_in,
  output logic [7:0] pkt_size_out,
  output logic [7:0] win_size_in,
  output logic [7:0] win_size_out,
  output logic [8:0] bytes_used,
  output logic       malformed
);
  import x25fp_pkg::*;

  beat_t   in_beat;
  beat_t   held_beat;
  logic    held_valid;
  logic    advance;
  logic    emit;
  logic    load;
  logic    slot_free;
  result_t walk_result;
  result_t out_result;

  assign in_beat.data_byte = data_byte;
  assign in_beat.start_req = start_req;

  // advance the held beat unless it ends a field and the result slot is busy
  assign advance = held_valid && (!emit || slot_free);
  assign load    = advance && emit;

  x25fp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_beat    (in_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  x25fp_walker u_walk (
    .clk    (clk),
    .rst    (rst),
    .beat   (held_beat),
    .step   (advance),
    .emit   (emit),
    .result (walk_result)
  );

  x25fp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .load_result (walk_result),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_result  (out_result)
  );

  assign reverse_charge = out_result.reverse_charge;
  assign throughput     = out_result.throughput;
  assign pkt_size_in    = out_result.pkt_size_in;
  assign pkt_size_out   = out_result.pkt_size_out;
  assign win_size_in    = out_result.win_size_in;
  assign win_size_out   = out_result.win_size_out;
  assign bytes_used     = out_result.bytes_used;
  assign malformed      = out_result.malformed;

  a_load_has_slot : assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled result");

  a_stall_needs_beat : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held_valid && emit && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_used_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bytes_used != 9'd0))
    else $error("result with zero bytes used");

  a_malformed_len : assert property (@(posedge clk) disable iff (rst)
    (out_valid && malformed) |-> (bytes_used >= 9'd2))
    else $error("malformed flag on an empty field");

endmodule
